// ===== design/adrc_pkg.sv =====
// adrc_pkg: shared types and constants for the audio depth and rate converter
// used by adrc_csr, adrc_core and audio_depth_rate_converter; no dependencies
`timescale 1ns / 1ps

package adrc_pkg;

   // widths
   localparam int COUNT_BITS = 24;
   localparam int RATE_BITS  = 16;
   localparam int ACC_BITS   = 17;
   localparam int SUM_BITS   = ACC_BITS + 1;
   localparam int BYTE_BITS  = 8;
   localparam int OUT_COUNT_BITS = 24;
   localparam int CSR_INDEX_BITS = 2;

   // sign bit of a byte sample
   localparam logic [BYTE_BITS-1:0] SIGN_FLIP = 8'h80;

   // register reset values
   localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd11025;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_IS_16BIT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_RATE     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_RATE     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAKE_SIGNED     = 2'd3;

   // current configuration seen by the datapath
   typedef struct packed {
      logic                 source_is_16bit;
      logic [RATE_BITS-1:0] source_rate;
      logic [RATE_BITS-1:0] target_rate;
      logic                 make_signed;
   } cfg_type;

endpackage

// ===== design/adrc_csr.sv =====
// adrc_csr: configuration registers of the converter
// depends on adrc_pkg
`timescale 1ns / 1ps

module adrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [adrc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [adrc_pkg::RATE_BITS-1:0]      csr_wdata,
   output adrc_pkg::cfg_type                   cfg
);

   adrc_pkg::cfg_type cfg_ff;
   adrc_pkg::cfg_type cfg_in;

   // writes are always accepted, csr_ready is tied high
   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            adrc_pkg::CSR_SOURCE_IS_16BIT: cfg_in.source_is_16bit = csr_wdata[0];
            adrc_pkg::CSR_SOURCE_RATE:     cfg_in.source_rate     = csr_wdata;
            adrc_pkg::CSR_TARGET_RATE:     cfg_in.target_rate     = csr_wdata;
            adrc_pkg::CSR_MAKE_SIGNED:     cfg_in.make_signed     = csr_wdata[0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_is_16bit <= 1'b0;
         cfg_ff.source_rate     <= adrc_pkg::RATE_RESET;
         cfg_ff.target_rate     <= adrc_pkg::RATE_RESET;
         cfg_ff.make_signed     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/adrc_core.sv =====
// adrc_core: byte pairing, phase accumulator decimation, sample count and
// the result register; depends on adrc_pkg
`timescale 1ns / 1ps

module adrc_core (
   input  logic                                clock,
   input  logic                                reset,
   input  adrc_pkg::cfg_type                   cfg,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [adrc_pkg::BYTE_BITS-1:0]      req_raw_byte,
   input  logic                                req_entry_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [adrc_pkg::BYTE_BITS-1:0]      rsp_sample,
   output logic                                rsp_has_sample,
   output logic                                rsp_entry_done,
   output logic [adrc_pkg::OUT_COUNT_BITS-1:0] rsp_bytes_written
);

   // entry state
   logic                              awaiting_ff, awaiting_in;
   logic [adrc_pkg::ACC_BITS-1:0]     acc_ff, acc_in;
   logic [adrc_pkg::COUNT_BITS-1:0]   count_ff, count_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [adrc_pkg::BYTE_BITS-1:0]    sample_ff, sample_in;
   logic                              has_sample_ff, has_sample_in;
   logic                              done_ff, done_in;
   logic [adrc_pkg::OUT_COUNT_BITS-1:0] written_ff, written_in;

   logic                              accept;
   logic                              have;
   logic                              pass;
   logic                              reach;
   logic                              emit;
   logic [adrc_pkg::BYTE_BITS-1:0]    value;
   logic [adrc_pkg::SUM_BITS-1:0]     sum;
   logic [adrc_pkg::SUM_BITS-1:0]     sum_red;

   // hold off new requests only while a result waits and the sink stalls
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // byte pairing: 16-bit mode keeps the high byte with its sign inverted
   assign have  = !cfg.source_is_16bit || awaiting_ff;
   assign value = cfg.source_is_16bit ? (req_raw_byte ^ adrc_pkg::SIGN_FLIP) : req_raw_byte;

   // phase accumulator step
   assign pass    = (cfg.source_rate == '0) || (cfg.target_rate >= cfg.source_rate);
   assign sum     = adrc_pkg::SUM_BITS'(acc_ff) + adrc_pkg::SUM_BITS'(cfg.target_rate);
   assign reach   = sum >= adrc_pkg::SUM_BITS'(cfg.source_rate);
   assign sum_red = reach ? (sum - adrc_pkg::SUM_BITS'(cfg.source_rate)) : sum;
   assign emit    = have && (pass || reach);

   // next entry state, cleared after the last byte
   always_comb begin
      awaiting_in = cfg.source_is_16bit && !awaiting_ff;
      acc_in      = (have && !pass) ? sum_red[adrc_pkg::ACC_BITS-1:0] : acc_ff;
      count_in    = (emit && (count_ff != '1)) ? count_ff + 1'b1 : count_ff;
      if (req_entry_last) begin
         awaiting_in = 1'b0;
         acc_in      = '0;
         count_in    = '0;
      end
   end

   // result fields
   always_comb begin
      sample_in     = '0;
      if (emit) begin
         sample_in = cfg.make_signed ? (value ^ adrc_pkg::SIGN_FLIP) : value;
      end
      has_sample_in = emit;
      done_in       = req_entry_last;
      written_in    = adrc_pkg::OUT_COUNT_BITS'(
                         (emit && (count_ff != '1)) ? count_ff + 1'b1 : count_ff);
   end

   // result valid: set on accept, cleared once taken
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            awaiting_ff <= awaiting_in;
            acc_ff      <= acc_in;
            count_ff    <= count_in;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff     <= sample_in;
         has_sample_ff <= has_sample_in;
         done_ff       <= done_in;
         written_ff    <= written_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = sample_ff;
   assign rsp_has_sample    = has_sample_ff;
   assign rsp_entry_done    = done_ff;
   assign rsp_bytes_written = written_ff;

endmodule

// ===== design/audio_depth_rate_converter.sv =====
// audio_depth_rate_converter: top level of the 16 to 8 bit converter and decimator
// depends on adrc_pkg, adrc_csr and adrc_core
//
//   channel   handshake             payload
//   req       req_valid/req_stall   req_raw_byte, req_entry_last
//   rsp       rsp_valid/rsp_stall   rsp_sample, rsp_has_sample, rsp_entry_done,
//                                   rsp_bytes_written
//   csr       csr_valid/csr_ready   csr_index, csr_wdata
//
// one request a cycle unless stalled; each result appears in the cycle after its
// request, set by the single result register after the accumulator add and compare
// synchronous active high reset sets csr defaults and clears valid and entry state
// a request is still taken while a result waits, unless the sink stalls
// csr writes are always accepted and registered
`timescale 1ns / 1ps

module audio_depth_rate_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [adrc_pkg::BYTE_BITS-1:0]      req_raw_byte,
   input  logic                                req_entry_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [adrc_pkg::BYTE_BITS-1:0]      rsp_sample,
   output logic                                rsp_has_sample,
   output logic                                rsp_entry_done,
   output logic [adrc_pkg::OUT_COUNT_BITS-1:0] rsp_bytes_written,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [adrc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [adrc_pkg::RATE_BITS-1:0]      csr_wdata
);

   adrc_pkg::cfg_type cfg;

   // configuration registers
   adrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // datapath and result register
   adrc_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_byte      (req_raw_byte),
      .req_entry_last    (req_entry_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample        (rsp_sample),
      .rsp_has_sample    (rsp_has_sample),
      .rsp_entry_done    (rsp_entry_done),
      .rsp_bytes_written (rsp_bytes_written)
   );

`ifndef NO_ASSERTIONS
   // request stall only comes from a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // an accepted request gives a result in the next cycle carrying its last flag
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (rsp_valid && (rsp_entry_done == $past(req_entry_last))))
      else $error("result missing or last flag lost");

   // no sample value without a sample
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_sample) |-> (rsp_sample == '0))
      else $error("sample nonzero without has_sample");
`endif

endmodule
